@@ rtl/core/vlbq_pkg.sv @@
// Shared constants and codes for the variable-length byte ring queue.
package vlbq_pkg;

  // Ring geometry; BUFFER_BYTES must be a power of two so ring pointers wrap naturally.
  localparam int BUFFER_BYTES     = 1024;
  localparam int MAX_ELEM_BYTES   = 64;
  localparam int LEN_PREFIX_BYTES = 4;
  localparam int START_BACKOFF    = 70;

  localparam int ADDR_W = $clog2(BUFFER_BYTES);
  localparam int FREE_W = 11;
  localparam int LEN_W  = 7;
  localparam int KIND_W = 3;
  localparam int STAT_W = 2;
  localparam int BYTE_W = 8;
  localparam int PCNT_W = (LEN_PREFIX_BYTES > 1) ? $clog2(LEN_PREFIX_BYTES) : 1;

  // Operation codes
  localparam logic [KIND_W-1:0] KIND_PUSH_HDR  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PUSH_BYTE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_POP       = 3'd2;
  localparam logic [KIND_W-1:0] KIND_PEEK      = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CLEAR     = 3'd4;

  // Status codes
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NOMEM = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;
  localparam logic [STAT_W-1:0] STAT_SEQ   = 2'd3;

endpackage

@@ rtl/core/variable_length_byte_ring_queue.sv @@
// Variable-length byte ring queue: 1024-byte ring of length-prefixed elements, one byte-wide RAM.
//
// Elements live in a single-port byte RAM (one access per cycle, registered read) as a
// 4-byte little-endian length prefix followed by the data, wrapping at the ring end.
// Push byte, clear, and every rejected command give one transaction, registered on acceptance.
// A push header writes the 4-byte prefix in S_WR_LEN, then its status appears from S_DONE.
// Pop and peek read the prefix in S_RD_LEN and size the transfer in S_CALC, then stream
// one data byte per cycle while out_ready stays high, the last byte marked by last.
// The RAM is never cleared; entries are only read after they have been written.
// A new command is taken only once the previous one has fully delivered its results.
module variable_length_byte_ring_queue (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [vlbq_pkg::KIND_W-1:0] kind,
  input  logic [vlbq_pkg::LEN_W-1:0]  elem_len,
  input  logic [vlbq_pkg::BYTE_W-1:0] data_byte,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [vlbq_pkg::STAT_W-1:0] status,
  output logic [vlbq_pkg::BYTE_W-1:0] out_byte,
  output logic                        byte_valid,
  output logic                        last,
  output logic [vlbq_pkg::FREE_W-1:0] free_bytes,
  output logic                        is_empty
);

  import vlbq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WR_LEN,
    S_RD_LEN,
    S_CALC,
    S_STREAM,
    S_DONE
  } state_t;

  localparam logic [FREE_W-1:0] FREE_FULL  = FREE_W'(BUFFER_BYTES);
  localparam logic [ADDR_W-1:0] HEAD_RESET = ADDR_W'(BUFFER_BYTES - START_BACKOFF);
  localparam logic [PCNT_W-1:0] PCNT_LAST  = PCNT_W'(LEN_PREFIX_BYTES - 1);
  localparam logic [FREE_W-1:0] PREFIX_F   = FREE_W'(LEN_PREFIX_BYTES);
  localparam logic [LEN_W-1:0]  MAX_LEN    = LEN_W'(MAX_ELEM_BYTES);

  state_t              state;
  logic [ADDR_W-1:0]   head;
  logic [ADDR_W-1:0]   tail;
  logic [ADDR_W-1:0]   ptr;
  logic [FREE_W-1:0]   free_cnt;
  logic [LEN_W-1:0]    open_rem;
  logic [LEN_W-1:0]    len_q;
  logic [LEN_W-1:0]    n_rem;
  logic [PCNT_W-1:0]   cnt;
  logic                is_pop;
  logic [STAT_W-1:0]   res_status;
  logic [BYTE_W-1:0]   len_bytes [LEN_PREFIX_BYTES];

  // byte RAM
  logic [BYTE_W-1:0]   ring_mem [BUFFER_BYTES];
  logic [BYTE_W-1:0]   rd_data;
  logic                mem_we;
  logic                mem_re;
  logic [ADDR_W-1:0]   mem_waddr;
  logic [ADDR_W-1:0]   mem_raddr;
  logic [BYTE_W-1:0]   mem_wdata;

  logic                slot_free;
  logic                in_fire;
  logic                fits;
  logic [31:0]         stored_w;
  logic [32:0]         credit_w;
  logic [FREE_W-1:0]   room;
  logic [LEN_W-1:0]    n_deliver;
  logic [LEN_W-1:0]    n_cap;

  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == S_IDLE) && slot_free;
  assign in_fire   = in_valid && in_ready;

  assign fits = (elem_len <= MAX_LEN) &&
                (free_cnt >= (FREE_W'(elem_len) + PREFIX_F));

  // Prefix bytes assembled little-endian
  always_comb begin
    stored_w = '0;
    for (int i = 0; i < LEN_PREFIX_BYTES; i++) begin
      stored_w[8*i +: 8] = len_bytes[i];
    end
  end

  assign credit_w  = {1'b0, stored_w} + 33'(LEN_PREFIX_BYTES);
  assign room      = FREE_FULL - free_cnt;
  assign n_cap     = (stored_w > 32'(len_q)) ? len_q : stored_w[LEN_W-1:0];
  assign n_deliver = (n_cap > MAX_LEN) ? MAX_LEN : n_cap;

  // RAM access control
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = tail;
    mem_raddr = ptr;
    mem_wdata = data_byte;
    case (state)
      S_IDLE: begin
        if (in_fire && kind == KIND_PUSH_BYTE && open_rem != '0) begin
          mem_we = 1'b1;
        end
        if (in_fire && (kind == KIND_POP || kind == KIND_PEEK) && open_rem == '0 &&
            free_cnt != FREE_FULL) begin
          mem_re    = 1'b1;
          mem_raddr = head;
        end
      end
      S_WR_LEN: begin
        mem_we    = 1'b1;
        mem_wdata = (cnt == '0) ? BYTE_W'(len_q) : '0;
      end
      S_RD_LEN: mem_re = (cnt != PCNT_LAST);
      S_CALC:   mem_re = (n_deliver != '0);
      S_STREAM: mem_re = slot_free && (n_rem > LEN_W'(1));
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= ring_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      head       <= HEAD_RESET;
      tail       <= HEAD_RESET;
      ptr        <= HEAD_RESET;
      free_cnt   <= FREE_FULL;
      open_rem   <= '0;
      cnt        <= '0;
      n_rem      <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            // default: one-shot result, state unchanged
            out_valid  <= 1'b1;
            out_byte   <= '0;
            byte_valid <= 1'b0;
            last       <= 1'b1;
            status     <= STAT_SEQ;
            free_bytes <= free_cnt;
            is_empty   <= (free_cnt == FREE_FULL);
            len_q      <= elem_len;
            is_pop     <= (kind == KIND_POP);
            cnt        <= '0;
            case (kind)
              KIND_PUSH_HDR: begin
                if (open_rem == '0) begin
                  if (fits) begin
                    out_valid <= 1'b0;
                    free_cnt  <= free_cnt - (FREE_W'(elem_len) + PREFIX_F);
                    open_rem  <= elem_len;
                    state     <= S_WR_LEN;
                  end else begin
                    status <= STAT_NOMEM;
                  end
                end
              end
              KIND_PUSH_BYTE: begin
                if (open_rem != '0) begin
                  status   <= STAT_OK;
                  tail     <= tail + ADDR_W'(1);
                  open_rem <= open_rem - LEN_W'(1);
                end
              end
              KIND_POP, KIND_PEEK: begin
                if (open_rem == '0) begin
                  if (free_cnt == FREE_FULL) begin
                    status <= STAT_EMPTY;
                  end else begin
                    out_valid <= 1'b0;
                    ptr       <= head + ADDR_W'(1);
                    state     <= S_RD_LEN;
                  end
                end
              end
              KIND_CLEAR: begin
                status     <= STAT_OK;
                free_cnt   <= FREE_FULL;
                free_bytes <= FREE_FULL;
                is_empty   <= 1'b1;
                tail       <= head;
                open_rem   <= '0;
              end
              default: ;
            endcase
          end
        end
        S_WR_LEN: begin
          tail <= tail + ADDR_W'(1);
          cnt  <= cnt + PCNT_W'(1);
          if (cnt == PCNT_LAST) begin
            res_status <= STAT_OK;
            state      <= S_DONE;
          end
        end
        S_RD_LEN: begin
          len_bytes[cnt] <= rd_data;
          if (cnt == PCNT_LAST) begin
            state <= S_CALC;
          end else begin
            cnt <= cnt + PCNT_W'(1);
            ptr <= ptr + ADDR_W'(1);
          end
        end
        S_CALC: begin
          // ptr sits just past the prefix here
          if (is_pop) begin
            head <= ptr + stored_w[ADDR_W-1:0];
            if (stored_w > 32'(BUFFER_BYTES) || credit_w > 33'(room)) begin
              free_cnt <= FREE_FULL;
            end else begin
              free_cnt <= free_cnt + credit_w[FREE_W-1:0];
            end
          end
          if (n_deliver == '0) begin
            res_status <= STAT_OK;
            state      <= S_DONE;
          end else begin
            ptr   <= ptr + ADDR_W'(1);
            n_rem <= n_deliver;
            state <= S_STREAM;
          end
        end
        S_STREAM: begin
          if (slot_free) begin
            out_valid  <= 1'b1;
            status     <= STAT_OK;
            out_byte   <= rd_data;
            byte_valid <= 1'b1;
            last       <= (n_rem == LEN_W'(1));
            free_bytes <= free_cnt;
            is_empty   <= (free_cnt == FREE_FULL);
            if (n_rem == LEN_W'(1)) begin
              state <= S_IDLE;
            end else begin
              ptr   <= ptr + ADDR_W'(1);
              n_rem <= n_rem - LEN_W'(1);
            end
          end
        end
        S_DONE: begin
          if (slot_free) begin
            out_valid  <= 1'b1;
            status     <= res_status;
            out_byte   <= '0;
            byte_valid <= 1'b0;
            last       <= 1'b1;
            free_bytes <= free_cnt;
            is_empty   <= (free_cnt == FREE_FULL);
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ dv/variable_length_byte_ring_queue_tb.sv @@
// Self-checking testbench for the variable-length byte ring queue.
module variable_length_byte_ring_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import vlbq_pkg::*;

  // kinds outside the defined set
  localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd5;
  localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;
  localparam int LEN_MAX_FIELD = (1 << LEN_W) - 1;
  localparam int RANDOM_ITEMS = 186;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 20;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [KIND_W-1:0] kind = KIND_CLEAR;
  logic [LEN_W-1:0] elem_len = '0;
  logic [BYTE_W-1:0] data_byte = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [STAT_W-1:0] status;
  logic [BYTE_W-1:0] out_byte;
  logic byte_valid;
  logic last;
  logic [FREE_W-1:0] free_bytes;
  logic is_empty;

  variable_length_byte_ring_queue dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [BYTE_W-1:0] out_byte;
    logic              byte_valid;
    logic              last;
    logic [FREE_W-1:0] free_bytes;
    logic              is_empty;
  } queue_reply_t;

  typedef struct packed {
    logic [KIND_W-1:0] op;
    logic [LEN_W-1:0]  len;
    logic [BYTE_W-1:0] data;
    logic              fixed;      // expected answer typed in below
    logic [STAT_W-1:0] fix_status;
    logic [FREE_W-1:0] fix_free;
  } step_row_t;

  localparam int N_DIRECTED = 24;
  step_row_t directed_rows [N_DIRECTED] = '{
    '{KIND_POP,       7'd5,   8'h00, 1'b1, STAT_EMPTY, 11'd1024},
    '{KIND_PEEK,      7'd0,   8'h00, 1'b1, STAT_EMPTY, 11'd1024},
    '{KIND_PUSH_BYTE, 7'd0,   8'hFF, 1'b1, STAT_SEQ,   11'd1024},
    '{KIND_SPARE_LO,  7'd127, 8'hFF, 1'b1, STAT_SEQ,   11'd1024},
    '{KIND_SPARE_HI,  7'd64,  8'h00, 1'b1, STAT_SEQ,   11'd1024},
    '{KIND_PUSH_HDR,  7'd65,  8'h00, 1'b1, STAT_NOMEM, 11'd1024},
    '{KIND_PUSH_HDR,  7'd127, 8'h00, 1'b1, STAT_NOMEM, 11'd1024},
    '{KIND_PUSH_HDR,  7'd0,   8'h00, 1'b1, STAT_OK,    11'd1020},
    '{KIND_POP,       7'd127, 8'h00, 1'b1, STAT_OK,    11'd1024},
    '{KIND_PUSH_HDR,  7'd3,   8'h00, 1'b1, STAT_OK,    11'd1017},
    '{KIND_PUSH_HDR,  7'd1,   8'h00, 1'b1, STAT_SEQ,   11'd1017},
    '{KIND_PEEK,      7'd4,   8'h00, 1'b1, STAT_SEQ,   11'd1017},
    '{KIND_POP,       7'd4,   8'h00, 1'b1, STAT_SEQ,   11'd1017},
    '{KIND_PUSH_BYTE, 7'd0,   8'h00, 1'b1, STAT_OK,    11'd1017},
    '{KIND_PUSH_BYTE, 7'd127, 8'hFF, 1'b1, STAT_OK,    11'd1017},
    '{KIND_PUSH_BYTE, 7'd0,   8'hA5, 1'b1, STAT_OK,    11'd1017},
    '{KIND_PEEK,      7'd2,   8'h00, 1'b0, STAT_OK,    11'd0},
    '{KIND_PEEK,      7'd0,   8'h00, 1'b1, STAT_OK,    11'd1017},
    '{KIND_POP,       7'd1,   8'h00, 1'b0, STAT_OK,    11'd0},
    '{KIND_PUSH_HDR,  7'd64,  8'h00, 1'b1, STAT_OK,    11'd956},
    '{KIND_PUSH_BYTE, 7'd0,   8'h5A, 1'b0, STAT_OK,    11'd0},
    '{KIND_CLEAR,     7'd0,   8'h00, 1'b1, STAT_OK,    11'd1024},
    '{KIND_PUSH_BYTE, 7'd0,   8'h3C, 1'b1, STAT_SEQ,   11'd1024},
    '{KIND_POP,       7'd64,  8'h00, 1'b1, STAT_EMPTY, 11'd1024}
  };

  // predictor state
  logic [BYTE_W-1:0] ring_image [BUFFER_BYTES];
  int ring_head = BUFFER_BYTES - START_BACKOFF;
  int ring_tail = BUFFER_BYTES - START_BACKOFF;
  int ring_free = BUFFER_BYTES;
  int bytes_owed = 0;

  queue_reply_t expected_replies [$];
  queue_reply_t want;
  int mismatches = 0;
  int replies_seen = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;

  function automatic queue_reply_t make_reply(logic [STAT_W-1:0] st, logic [BYTE_W-1:0] b,
                                              logic bv, logic lst);
    return '{st, b, bv, lst, FREE_W'(ring_free), ring_free == BUFFER_BYTES};
  endfunction

  task automatic predict_command(input logic [KIND_W-1:0] op, input logic [LEN_W-1:0] len,
                                 input logic [BYTE_W-1:0] data);
    int i, pos, stored, cnt, credit;
    case (op)
      KIND_PUSH_HDR: begin
        if (bytes_owed != 0) begin
          expected_replies.push_back(make_reply(STAT_SEQ, '0, 1'b0, 1'b1));
        end else if (len > MAX_ELEM_BYTES || ring_free < len + LEN_PREFIX_BYTES) begin
          expected_replies.push_back(make_reply(STAT_NOMEM, '0, 1'b0, 1'b1));
        end else begin
          ring_free -= len + LEN_PREFIX_BYTES;
          for (i = 0; i < LEN_PREFIX_BYTES; i++) begin
            ring_image[ring_tail] = BYTE_W'(int'(len) >> (8 * i));
            ring_tail = (ring_tail + 1) % BUFFER_BYTES;
          end
          bytes_owed = len;
          expected_replies.push_back(make_reply(STAT_OK, '0, 1'b0, 1'b1));
        end
      end
      KIND_PUSH_BYTE: begin
        if (bytes_owed == 0) begin
          expected_replies.push_back(make_reply(STAT_SEQ, '0, 1'b0, 1'b1));
        end else begin
          ring_image[ring_tail] = data;
          ring_tail = (ring_tail + 1) % BUFFER_BYTES;
          bytes_owed--;
          expected_replies.push_back(make_reply(STAT_OK, '0, 1'b0, 1'b1));
        end
      end
      KIND_POP, KIND_PEEK: begin
        if (bytes_owed != 0) begin
          expected_replies.push_back(make_reply(STAT_SEQ, '0, 1'b0, 1'b1));
        end else if (ring_free == BUFFER_BYTES) begin
          expected_replies.push_back(make_reply(STAT_EMPTY, '0, 1'b0, 1'b1));
        end else begin
          pos = ring_head;
          stored = 0;
          for (i = 0; i < LEN_PREFIX_BYTES; i++) begin
            stored |= int'(ring_image[pos]) << (8 * i);
            pos = (pos + 1) % BUFFER_BYTES;
          end
          cnt = (stored < len) ? stored : int'(len);
          if (cnt > MAX_ELEM_BYTES) cnt = MAX_ELEM_BYTES;
          if (op == KIND_POP) begin
            // head skips the whole element, delivered or not
            ring_head = (pos + stored % BUFFER_BYTES) % BUFFER_BYTES;
            credit = stored + LEN_PREFIX_BYTES;
            if (stored > BUFFER_BYTES || credit > BUFFER_BYTES - ring_free)
              ring_free = BUFFER_BYTES;
            else
              ring_free += credit;
          end
          if (cnt == 0) begin
            expected_replies.push_back(make_reply(STAT_OK, '0, 1'b0, 1'b1));
          end else begin
            for (i = 0; i < cnt; i++) begin
              expected_replies.push_back(make_reply(STAT_OK, ring_image[pos], 1'b1,
                                                    i == cnt - 1));
              pos = (pos + 1) % BUFFER_BYTES;
            end
          end
        end
      end
      KIND_CLEAR: begin
        ring_free = BUFFER_BYTES;
        ring_tail = ring_head;
        bytes_owed = 0;
        expected_replies.push_back(make_reply(STAT_OK, '0, 1'b0, 1'b1));
      end
      default: begin
        expected_replies.push_back(make_reply(STAT_SEQ, '0, 1'b0, 1'b1));
      end
    endcase
  endtask

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_command(input logic [KIND_W-1:0] op, input logic [LEN_W-1:0] len,
                              input logic [BYTE_W-1:0] data, input logic fixed = 1'b0,
                              input logic [STAT_W-1:0] fix_status = STAT_OK,
                              input logic [FREE_W-1:0] fix_free = '0);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    kind <= op;
    elem_len <= len;
    data_byte <= data;
    do @(posedge clk); while (!in_ready);
    predict_command(op, len, data);
    if (fixed)
      expected_replies[expected_replies.size() - 1] =
        '{fix_status, '0, 1'b0, 1'b1, fix_free, fix_free == BUFFER_BYTES};
    @(negedge clk);
  endtask

  // header plus 'keep' data bytes; keep < len leaves the element open
  task automatic push_element(input int len, input int keep);
    int j;
    send_command(KIND_PUSH_HDR, LEN_W'(len), BYTE_W'($urandom));
    for (j = 0; j < keep; j++)
      send_command(KIND_PUSH_BYTE, LEN_W'($urandom), BYTE_W'($urandom));
  endtask

  function automatic logic [LEN_W-1:0] random_cap();
    case ($urandom_range(3))
      0: return '0;
      1: return LEN_W'($urandom_range(1, MAX_ELEM_BYTES - 1));
      2: return LEN_W'(MAX_ELEM_BYTES);
      default: return LEN_W'($urandom_range(MAX_ELEM_BYTES + 1, LEN_MAX_FIELD));
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      replies_seen++;
      if (expected_replies.size() == 0) begin
        $error("unexpected transaction: status %0d out_byte %0d", status, out_byte);
        mismatches++;
      end else begin
        want = expected_replies.pop_front();
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          mismatches++;
        end
        if (out_byte !== want.out_byte) begin
          $error("out_byte: expected %0d, got %0d", want.out_byte, out_byte);
          mismatches++;
        end
        if (byte_valid !== want.byte_valid) begin
          $error("byte_valid: expected %0d, got %0d", want.byte_valid, byte_valid);
          mismatches++;
        end
        if (last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, last);
          mismatches++;
        end
        if (free_bytes !== want.free_bytes) begin
          $error("free_bytes: expected %0d, got %0d", want.free_bytes, free_bytes);
          mismatches++;
        end
        if (is_empty !== want.is_empty) begin
          $error("is_empty: expected %0d, got %0d", want.is_empty, is_empty);
          mismatches++;
        end
      end
    end
  end

  // Receiver; one long hold-off backs the block up into its input side.
  initial begin : rx_drive
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && replies_seen >= 40) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  initial begin : stimulus
    int sent, n, keep, r;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    tx_idle_pct = 33;
    rx_idle_pct = 64;
    foreach (directed_rows[i])
      send_command(directed_rows[i].op, directed_rows[i].len, directed_rows[i].data,
                   directed_rows[i].fixed, directed_rows[i].fix_status,
                   directed_rows[i].fix_free);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent < RANDOM_ITEMS / 2) begin
        tx_idle_pct = 64;
        rx_idle_pct = 33;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      r = $urandom_range(99);
      if (r < 45) begin
        r = $urandom_range(99);
        if (r < 70) n = $urandom_range(0, 8);
        else if (r < 95) n = $urandom_range(9, MAX_ELEM_BYTES);
        else n = $urandom_range(MAX_ELEM_BYTES + 1, LEN_MAX_FIELD);
        if (n > MAX_ELEM_BYTES) keep = $urandom_range(0, 2);
        else if ($urandom_range(9) == 0) keep = $urandom_range(0, n);
        else keep = n;
        push_element(n, keep);
        sent += 1 + keep;
      end else begin
        if (r < 65) send_command(KIND_POP, random_cap(), BYTE_W'($urandom));
        else if (r < 75) send_command(KIND_PEEK, random_cap(), BYTE_W'($urandom));
        else if (r < 80) send_command(KIND_CLEAR, LEN_W'($urandom), BYTE_W'($urandom));
        else send_command(KIND_W'($urandom), LEN_W'($urandom), BYTE_W'($urandom));
        sent++;
      end
    end
    in_valid <= 1'b0;

    while (expected_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/vlbq_pkg.sv
rtl/core/variable_length_byte_ring_queue.sv
dv/variable_length_byte_ring_queue_tb.sv
